// File: sv/nbody_gravity_position_step_assert.svh
// Assertion macros for the gravity position step block.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef NBODY_GRAVITY_POSITION_STEP_ASSERT_SVH
`define NBODY_GRAVITY_POSITION_STEP_ASSERT_SVH

// Implication checked on the same edge, disabled while in reset.
`define NGPS_ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked on the edge after the antecedent.
`define NGPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ngps_pkg.sv
// Shared types and constants for the gravity position step block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ngps_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int TS_FRAC       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = 64;

  localparam logic [63:0] GRAV_RESET = 64'd1231172500;
  localparam logic [23:0] DT_RESET   = 24'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT   = 2'd1;

  // Datapath operations, in the order the sequencer normally runs them.
  typedef enum logic [4:0] {
    OP_SQX, OP_SQY, OP_SQRT, OP_MM, OP_DIVT, OP_DIVU,
    OP_MULX, OP_DIVX, OP_GMX, OP_MULY, OP_DIVY, OP_GMY,
    OP_ADIVX, OP_ADIVY, OP_DTSQ, OP_AMX, OP_AMY, OP_VMX, OP_VMY
  } op_t;

  typedef struct packed {
    logic        [39:0] tgt_mass;
    logic signed [39:0] tgt_x;
    logic signed [39:0] tgt_y;
    logic signed [39:0] tgt_vx;
    logic signed [39:0] tgt_vy;
    logic        [39:0] src_mass;
    logic signed [39:0] src_x;
    logic signed [39:0] src_y;
    logic               last_source;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] new_x;
    logic signed [39:0] new_y;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic start;
    op_t  op;
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic dist_zero;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/ngps_ctrl.sv
// Sequencer for the gravity position step: steps the datapath through its operations.
// Depends on ngps_pkg.
`timescale 1ns / 1ps

module ngps_ctrl import ngps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   wait_r, wait_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    wait_nxt  = wait_r;
    cmd.start = 1'b0;
    cmd.op    = op_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
          op_nxt    = OP_SQX;
          wait_nxt  = 1'b0;
        end
      end
      ST_RUN: begin
        if (!wait_r) begin
          cmd.start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (st.done) begin
          wait_nxt = 1'b0;
          case (op_r)
            OP_SQY: begin
              if (!st.dist_zero) begin
                op_nxt = OP_SQRT;
              end else if (st.last) begin
                op_nxt = OP_ADIVX;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            OP_GMY: begin
              if (st.last) begin
                op_nxt = OP_ADIVX;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            OP_VMY: begin
              state_nxt = ST_FIN;
            end
            default: begin
              op_nxt = op_t'(op_r + 5'd1);
            end
          endcase
        end
      end
      ST_FIN: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_SQX;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

// File: sv/ngps_dp.sv
// Datapath for the gravity position step: multiplier, divider, square root and sums.
// Depends on ngps_pkg; driven by ngps_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module ngps_dp import ngps_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  output out_item_t            out_data,
  output logic                 out_valid,
  input  logic                 out_stall
);

  localparam int ADT_SHIFT = 2 * TS_FRAC + 1;
  localparam logic [63:0] TERM_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] F_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  function automatic logic is_div(input op_t op);
    return op inside {OP_DIVT, OP_DIVU, OP_DIVX, OP_DIVY, OP_ADIVX, OP_ADIVY};
  endfunction

  // Saturating signed add; the top bit flags a clip.
  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return {1'b1, s[64], {63{~s[64]}}};
    end
    return {1'b0, s[63:0]};
  endfunction

  // New coordinate: position plus both terms, clamped to 40 bits; top bit flags a clip.
  function automatic logic [40:0] coord(input logic [39:0] pos, input logic vneg,
                                        input logic [47:0] vdt, input logic fneg,
                                        input logic [62:0] adt);
    logic signed [65:0] ps, tv, ta, s;
    ps = {{26{pos[39]}}, pos};
    tv = {18'b0, vdt};
    ta = {3'b0, adt};
    s  = ps + (vneg ? -tv : tv) + (fneg ? -ta : ta);
    if (s > 66'sd549755813887) begin
      return {1'b1, 40'h7F_FFFF_FFFF};
    end
    if (s < -66'sd549755813888) begin
      return {1'b1, 40'h80_0000_0000};
    end
    return {1'b0, s[39:0]};
  endfunction

  in_item_t    item_r;
  logic [63:0] grav_r;
  logic [23:0] dt_r;
  logic [40:0] ax_r, ay_r;
  logic        negx_r, negy_r;
  logic [81:0] r2_r;
  logic [41:0] r_r;
  logic [63:0] mm_r, t_r, u_r, v_r, amx_r, amy_r;
  logic [63:0] fsx_r, fsy_r;
  logic        clip_r;
  logic [47:0] dt2_r, vdtx_r, vdty_r;
  logic [62:0] adtx_r, adty_r;
  out_item_t   out_r;
  logic        out_valid_r, done_r, busy_r;
  op_t         op_r;
  logic [5:0]  cnt_r;
  logic [63:0] mul_a_r, mul_b_r;
  logic [127:0] acc_r;
  logic [63:0] num_lo_r, rem_r, den_r, quo_r;
  logic        dsat_r;
  logic [83:0] rad_r;
  logic [45:0] srem_r;
  logic [41:0] root_r;

  // Difference vector of the incoming pair.
  logic [40:0] dx, dy;
  assign dx = {in_data.src_x[39], in_data.src_x} - {in_data.tgt_x[39], in_data.tgt_x};
  assign dy = {in_data.src_y[39], in_data.src_y} - {in_data.tgt_y[39], in_data.tgt_y};

  // Magnitudes used by the final step.
  logic [39:0] magvx, magvy;
  logic [63:0] magfx, magfy;
  assign magvx = item_r.tgt_vx[39] ? 40'(-item_r.tgt_vx) : 40'(item_r.tgt_vx);
  assign magvy = item_r.tgt_vy[39] ? 40'(-item_r.tgt_vy) : 40'(item_r.tgt_vy);
  assign magfx = fsx_r[63] ? (64'd0 - fsx_r) : fsx_r;
  assign magfy = fsy_r[63] ? (64'd0 - fsy_r) : fsy_r;

  // Operand selection for the operation being started.
  logic [63:0]  opa, opb, dden;
  logic [127:0] dnum;
  always_comb begin
    opa  = '0;
    opb  = '0;
    dnum = '0;
    dden = {22'b0, r_r};
    case (cmd.op)
      OP_SQX:   begin opa = {23'b0, ax_r}; opb = {23'b0, ax_r}; end
      OP_SQY:   begin opa = {23'b0, ay_r}; opb = {23'b0, ay_r}; end
      OP_MM:    begin opa = {24'b0, item_r.tgt_mass}; opb = {24'b0, item_r.src_mass}; end
      OP_DIVT:  dnum = {64'b0, mm_r} << FRAC_BITS;
      OP_DIVU:  dnum = {64'b0, t_r} << FRAC_BITS;
      OP_MULX:  begin opa = u_r; opb = {23'b0, ax_r}; end
      OP_MULY:  begin opa = u_r; opb = {23'b0, ay_r}; end
      OP_DIVX,
      OP_DIVY:  dnum = acc_r;
      OP_GMX,
      OP_GMY:   begin opa = grav_r; opb = v_r; end
      OP_ADIVX: begin dnum = {64'b0, magfx} << FRAC_BITS; dden = {24'b0, item_r.tgt_mass}; end
      OP_ADIVY: begin dnum = {64'b0, magfy} << FRAC_BITS; dden = {24'b0, item_r.tgt_mass}; end
      OP_DTSQ:  begin opa = {40'b0, dt_r}; opb = {40'b0, dt_r}; end
      OP_AMX:   begin opa = amx_r; opb = {16'b0, dt2_r}; end
      OP_AMY:   begin opa = amy_r; opb = {16'b0, dt2_r}; end
      OP_VMX:   begin opa = {24'b0, magvx}; opb = {40'b0, dt_r}; end
      OP_VMY:   begin opa = {24'b0, magvy}; opb = {40'b0, dt_r}; end
      default:  begin opa = '0; end
    endcase
  end

  // Multiplier: one 32 by 32 partial product per cycle into a 128-bit accumulator.
  logic [31:0]  a_h, b_h;
  logic [63:0]  pp;
  logic [127:0] pp_sh, acc_nxt;
  assign a_h = cnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_h = cnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pp  = a_h * b_h;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end
  assign acc_nxt = acc_r + pp_sh;

  // Divider: restoring, one quotient bit per cycle.
  logic [64:0] dshift, ddiff;
  logic        dge;
  logic [63:0] rem_nxt, quo_nxt, dres;
  assign dshift  = {rem_r, num_lo_r[63]};
  assign ddiff   = dshift - {1'b0, den_r};
  assign dge     = (dshift >= {1'b0, den_r});
  assign rem_nxt = dge ? ddiff[63:0] : dshift[63:0];
  assign quo_nxt = {quo_r[62:0], dge};
  assign dres    = dsat_r ? '1 : quo_nxt;

  // Square root: one root bit per cycle.
  logic [45:0] ssh, strial;
  logic        sge;
  logic [41:0] root_nxt;
  assign ssh      = {srem_r[43:0], rad_r[83:82]};
  assign strial   = {2'b00, root_r, 2'b01};
  assign sge      = (ssh >= strial);
  assign root_nxt = {root_r[40:0], sge};

  logic unit_last, fin;
  always_comb begin
    if (is_div(op_r)) begin
      unit_last = (cnt_r == 6'd63);
    end else if (op_r == OP_SQRT) begin
      unit_last = (cnt_r == 6'd41);
    end else begin
      unit_last = (cnt_r == 6'd3);
    end
  end
  assign fin = busy_r & unit_last;

  // Result shaping for the write-back.
  logic [127:0] sh_f, sh_a, sh_v;
  logic         mm_ovf, a_ovf, gclip;
  logic [63:0]  adt_raw, adt_cap, gf, gval, gadd;
  logic [64:0]  gsum;
  assign sh_f    = acc_nxt >> FRAC_BITS;
  assign sh_a    = acc_nxt >> ADT_SHIFT;
  assign sh_v    = acc_nxt >> TS_FRAC;
  assign mm_ovf  = |(acc_nxt >> (64 + FRAC_BITS));
  assign a_ovf   = |(acc_nxt >> (64 + ADT_SHIFT));
  assign adt_raw = a_ovf ? '1 : sh_a[63:0];
  assign adt_cap = (adt_raw > TERM_CAP) ? TERM_CAP : adt_raw;
  assign gf      = acc_nxt[127:64];
  assign gclip   = gf[63];
  assign gval    = gclip ? F_MAX : gf;
  always_comb begin
    if (op_r == OP_GMX) begin
      gadd = negx_r ? (64'd0 - gval) : gval;
      gsum = sat_add(fsx_r, gadd);
    end else begin
      gadd = negy_r ? (64'd0 - gval) : gval;
      gsum = sat_add(fsy_r, gadd);
    end
  end

  logic [40:0] nx, ny;
  assign nx = coord(item_r.tgt_x, item_r.tgt_vx[39], vdtx_r, fsx_r[63], adtx_r);
  assign ny = coord(item_r.tgt_y, item_r.tgt_vy[39], vdty_r, fsy_r[63], adty_r);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Control, sums and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r      <= GRAV_RESET;
      dt_r        <= DT_RESET;
      fsx_r       <= '0;
      fsy_r       <= '0;
      clip_r      <= 1'b0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      done_r <= fin;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRAV: grav_r <= cfg_wdata;
          CFG_DT:   dt_r   <= cfg_wdata[23:0];
          default:  ;
        endcase
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (unit_last) begin
          busy_r <= 1'b0;
        end
      end
      if (fin) begin
        case (op_r)
          OP_MM:   clip_r <= clip_r | mm_ovf;
          OP_DIVT, OP_DIVU, OP_DIVX, OP_DIVY: clip_r <= clip_r | dsat_r;
          OP_GMX:  begin fsx_r <= gsum[63:0]; clip_r <= clip_r | gclip | gsum[64]; end
          OP_GMY:  begin fsy_r <= gsum[63:0]; clip_r <= clip_r | gclip | gsum[64]; end
          OP_ADIVX, OP_ADIVY: clip_r <= clip_r | (dsat_r & (item_r.tgt_mass != '0));
          OP_AMX, OP_AMY: clip_r <= clip_r | a_ovf;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        fsx_r       <= '0;
        fsy_r       <= '0;
        clip_r      <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand capture, unit iterations and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      ax_r   <= dx[40] ? (41'd0 - dx) : dx;
      ay_r   <= dy[40] ? (41'd0 - dy) : dy;
      negx_r <= dx[40];
      negy_r <= dy[40];
    end
    if (cmd.start) begin
      op_r     <= cmd.op;
      mul_a_r  <= opa;
      mul_b_r  <= opb;
      acc_r    <= '0;
      rem_r    <= dnum[127:64];
      num_lo_r <= dnum[63:0];
      den_r    <= dden;
      quo_r    <= '0;
      dsat_r   <= (dnum[127:64] >= dden);
      rad_r    <= {2'b00, r2_r};
      srem_r   <= '0;
      root_r   <= '0;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      rem_r    <= rem_nxt;
      num_lo_r <= {num_lo_r[62:0], 1'b0};
      quo_r    <= quo_nxt;
      srem_r   <= sge ? (ssh - strial) : ssh;
      root_r   <= root_nxt;
      rad_r    <= {rad_r[81:0], 2'b00};
    end
    if (fin) begin
      case (op_r)
        OP_SQX:   r2_r   <= acc_nxt[81:0];
        OP_SQY:   r2_r   <= r2_r + acc_nxt[81:0];
        OP_SQRT:  r_r    <= root_nxt;
        OP_MM:    mm_r   <= mm_ovf ? '1 : sh_f[63:0];
        OP_DIVT:  t_r    <= dres;
        OP_DIVU:  u_r    <= dres;
        OP_DIVX,
        OP_DIVY:  v_r    <= dres;
        OP_ADIVX: amx_r  <= (item_r.tgt_mass == '0) ? '0 : dres;
        OP_ADIVY: amy_r  <= (item_r.tgt_mass == '0) ? '0 : dres;
        OP_DTSQ:  dt2_r  <= acc_nxt[47:0];
        OP_AMX:   adtx_r <= adt_cap[62:0];
        OP_AMY:   adty_r <= adt_cap[62:0];
        OP_VMX:   vdtx_r <= sh_v[47:0];
        OP_VMY:   vdty_r <= sh_v[47:0];
        default:  ;
      endcase
    end
    if (cmd.emit) begin
      out_r.new_x     <= nx[39:0];
      out_r.new_y     <= ny[39:0];
      out_r.saturated <= clip_r | nx[40] | ny[40];
    end
  end

  assign st.done      = done_r;
  assign st.busy      = busy_r;
  assign st.dist_zero = (r2_r == '0);
  assign st.last      = item_r.last_source;
  assign st.out_free  = out_free;
  assign out_data     = out_r;
  assign out_valid    = out_valid_r;

endmodule

// File: sv/nbody_gravity_position_step.sv
// Gravity position step: one target/source pair per transaction, one result per last source.
// A source pair runs a square root, four divisions and seven multiplies; coincident bodies
// run only the two squaring multiplies. The last source adds the two acceleration divisions,
// five multiplies and the output write. One item at a time.
// Reset (synchronous, rst_n low) clears the force sums, the clip flag and the output valid,
// and loads the default gravitational coefficient and time step.
`timescale 1ns / 1ps
`include "nbody_gravity_position_step_assert.svh"

module nbody_gravity_position_step import ngps_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer.
  ngps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic units and state.
  ngps_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // Sequencing checks.
  `NGPS_ASSERT_IMPL(a_accept_idle, (in_valid && !in_stall) |-> !st.busy, "item taken while busy")
  `NGPS_ASSERT_IMPL(a_start_idle, cmd.start |-> !st.busy, "operation started while busy")
  `NGPS_ASSERT_IMPL(a_emit_free, cmd.emit |-> st.out_free, "result written over a pending one")
  `NGPS_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "result written but not presented")

endmodule
